[src/epoch_seconds_to_local_calendar_assert.svh]
// Assertion macros for the epoch to calendar block.
// Included by estlc_ctrl, the module that carries concurrent checks.
`ifndef EPOCH_SECONDS_TO_LOCAL_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_LOCAL_CALENDAR_ASSERT_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

[src/estlc_pkg.sv]
// Shared types and constants for the epoch to calendar block.
// No dependencies.
package estlc_pkg;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic CmdConvert = 1'b0;
  localparam logic CmdWrite = 1'b1;
  localparam logic RegStdOffset = 1'b0;
  localparam logic RegDstOffset = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_DIV, ST_YEAR, ST_MONTH, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic write;
    logic scan_start;
    logic scan_step;
    logic apply_dst;
    logic div_start;
    logic year_step;
    logic month_step;
  } ctl_t;

  typedef struct packed {
    logic cmd_write;
    logic scan_hit;
    logic scan_end;
    logic div_done;
    logic year_done;
    logic month_done;
  } sts_t;

  function automatic logic [8:0] year_len(input logic [7:0] ys);
    logic leap;
    leap = (ys[1:0] == 2'b00) && (ys != 8'd200);
    year_len = leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1: month_len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction
endpackage

[src/estlc_ctrl.sv]
// Controller state machine for the epoch to calendar block.
// Depends on estlc_pkg.
module estlc_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  estlc_pkg::sts_t sts,
  output estlc_pkg::ctl_t ctl
);
  import estlc_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts.cmd_write) begin
          ctl.write = 1'b1;
          state_next = ST_IDLE;
        end else begin
          ctl.scan_start = 1'b1;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.scan_hit) begin
          ctl.apply_dst = 1'b1;
          state_next = ST_DIV;
        end else if (sts.scan_end) begin
          state_next = ST_DIV;
        end else ctl.scan_step = 1'b1;
      end
      ST_DIV: begin
        ctl.div_start = 1'b1;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts.div_done && sts.year_done) state_next = ST_MONTH;
        else ctl.year_step = 1'b1;
      end
      ST_MONTH: begin
        if (sts.month_done) state_next = ST_OUT;
        else ctl.month_step = 1'b1;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `include "epoch_seconds_to_local_calendar_assert.svh"
  `ASSERT_IMPL(a_rdy_idle, clk, rst, in_ready, state == ST_IDLE)
  `ASSERT_IMPL(a_excl, clk, rst, in_ready, !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

[src/estlc_datapath.sv]
// Datapath: DST table memory, scan, day split, year and month walks.
// Depends on estlc_pkg.
module estlc_datapath #(
  parameter int DST_PAIRS = 128
) (
  input  logic clk,
  input  logic rst,
  input  estlc_pkg::ctl_t ctl,
  output estlc_pkg::sts_t sts,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [17:0] cfg_data,
  input  logic command,
  input  logic [7:0] table_index,
  input  logic [31:0] value,
  output logic [5:0] second,
  output logic [5:0] minute,
  output logic [4:0] hour,
  output logic [4:0] day_of_month,
  output logic [3:0] month,
  output logic [7:0] year_since_1900,
  output logic [2:0] weekday,
  output logic [8:0] day_of_year,
  output logic dst_active
);
  import estlc_pkg::*;
  localparam int Words = 2 * DST_PAIRS;
  localparam int Pw = (DST_PAIRS > 1) ? $clog2(DST_PAIRS) : 1;
  localparam int Cw = $clog2(DST_PAIRS + 1);
  localparam logic [25:0] DayRecip = 26'd50903317;
  localparam logic [16:0] WeekRecip = 17'd74899;
  localparam logic [13:0] HourRecip = 14'd9321;
  localparam logic [10:0] MinRecip = 11'd1093;

  logic [31:0] mem_s [DST_PAIRS];
  logic [31:0] mem_e [DST_PAIRS];
  // Separate start and end banks so valid bits cover both words.
  logic [DST_PAIRS-1:0] vld_s, vld_e;
  logic [31:0] rd_s, rd_e;
  logic [17:0] std_off, dst_off;
  logic cmd_r;
  logic [7:0] idx_r;
  logic [31:0] tim, t;
  logic wr_en;
  logic [Pw-1:0] wr_pair;
  logic [Cw-1:0] pair;
  logic [Pw-1:0] rd_addr;
  logic [15:0] day;
  logic [2:0] bitc;
  logic [16:0] hms;
  logic [7:0] ys;
  logic [8:0] doy;
  logic [3:0] mon;
  logic [4:0] mlen;
  logic leap;
  logic [50:0] day_prod;
  logic [32:0] day_secs;
  logic [16:0] day4;
  logic [33:0] wk_prod;
  logic [12:0] q7;
  logic [15:0] q7x7;
  logic [26:0] hr_prod;
  logic [4:0] hr;
  logic [16:0] hr_secs;
  logic [11:0] rest;
  logic [20:0] mn_prod;
  logic [5:0] mn;
  logic [11:0] mn_secs;

  always_ff @(posedge clk) begin
    if (rst) begin
      std_off <= '0;
      dst_off <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegStdOffset) std_off <= cfg_data;
      else dst_off <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= command;
      idx_r <= table_index;
      tim <= value;
      t <= value + {{14{std_off[17]}}, std_off};
    end else if (ctl.apply_dst) begin
      t <= tim + {{14{dst_off[17]}}, dst_off};
    end
  end

  assign sts.cmd_write = (cmd_r == CmdWrite);

  assign wr_en = ctl.write && ({24'd0, idx_r} < 32'(Words));
  assign wr_pair = Pw'(idx_r[7:1]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (idx_r[0]) mem_e[wr_pair] <= tim;
      else mem_s[wr_pair] <= tim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= '0;
      vld_e <= '0;
    end else if (wr_en) begin
      if (idx_r[0]) vld_e[wr_pair] <= 1'b1;
      else vld_s[wr_pair] <= 1'b1;
    end
  end

  assign rd_addr = ctl.scan_start ? '0 : Pw'(pair + Cw'(1));
  always_ff @(posedge clk) begin
    rd_s <= vld_s[rd_addr] ? mem_s[rd_addr] : 32'd0;
    rd_e <= vld_e[rd_addr] ? mem_e[rd_addr] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_start) pair <= '0;
    else if (ctl.scan_step) pair <= pair + Cw'(1);
  end

  assign sts.scan_hit = (rd_s != 32'd0) && (t >= rd_s) && (t < rd_e);
  assign sts.scan_end = (rd_s == 32'd0) || (pair == Cw'(DST_PAIRS - 1));

  always_ff @(posedge clk) begin
    if (rst) dst_active <= 1'b0;
    else if (ctl.load) dst_active <= 1'b0;
    else if (ctl.apply_dst) dst_active <= 1'b1;
  end

  // Day split by reciprocal multiply, one stage per cycle, bitc 5 down to 1.
  assign day_prod = 51'(t[31:7]) * 51'(DayRecip);
  assign day_secs = 33'(day) * 33'(SecsPerDay);
  assign day4 = {1'b0, day} + 17'd4;
  assign wk_prod = 34'(day4) * 34'(WeekRecip);
  assign q7x7 = 16'(q7) * 16'd7;
  assign hr_prod = 27'(hms[16:4]) * 27'(HourRecip);
  assign hr_secs = 17'(hr) * 17'd3600;
  assign mn_prod = 21'(rest[11:2]) * 21'(MinRecip);
  assign mn_secs = 12'(mn) * 12'd60;

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      bitc <= 3'd5;
      ys <= 8'd70;
    end else if (ctl.year_step && bitc != 3'd0) begin
      case (bitc)
        3'd5: day <= day_prod[50:35];
        3'd4: begin
          hms <= 17'(t - day_secs[31:0]);
          q7 <= wk_prod[31:19];
        end
        3'd3: begin
          weekday <= 3'(day4[15:0] - q7x7);
          hr <= hr_prod[25:21];
        end
        3'd2: rest <= 12'(hms - hr_secs);
        3'd1: mn <= mn_prod[19:14];
        default: ;
      endcase
      bitc <= bitc - 3'd1;
    end else if (ctl.year_step) begin
      day <= day - {7'd0, year_len(ys)};
      ys <= ys + 8'd1;
    end else if (ctl.month_step) begin
      day <= day - {11'd0, mlen};
    end
  end

  assign sts.div_done = (bitc == 3'd0);
  assign sts.year_done = day < {7'd0, year_len(ys)};
  assign leap = year_len(ys) == 9'd366;
  assign mlen = month_len(mon, leap);

  always_ff @(posedge clk) begin
    if (ctl.div_start) mon <= '0;
    else if (ctl.month_step) mon <= mon + 4'd1;
  end

  // Day of year is the day count left when the month walk starts.
  always_ff @(posedge clk) begin
    if (sts.div_done && mon == 4'd0) doy <= day[8:0];
  end

  assign sts.month_done = (mon == 4'd11) || (day < {11'd0, mlen});
  assign second = 6'(rest - mn_secs);
  assign minute = mn;
  assign hour = hr;
  assign day_of_month = day[4:0] + 5'd1;
  assign month = mon;
  assign year_since_1900 = ys;
  assign day_of_year = doy;
endmodule

[src/epoch_seconds_to_local_calendar.sv]
// Top level: epoch seconds to local calendar time.
// Depends on estlc_pkg, estlc_ctrl, estlc_datapath.
//  channel  signals                       dir
//  input    in_valid/in_ready + 3 fields  in
//  output   out_valid/out_ready + 9 fields out
//  config   cfg_we/cfg_index/cfg_data     in
// A table write returns to idle from ST_SCAN_RD; a conversion checks pairs (up to 128),
// splits the day, walks years past 1970 (up to 136) and walks months (up to 11).
// The result holds until taken; no item enters meanwhile. Reset is sync.
module epoch_seconds_to_local_calendar #(
  parameter int DST_PAIRS = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic [7:0] table_index,
  input  logic [31:0] value,
  output logic out_valid,
  input  logic out_ready,
  output logic [5:0] second,
  output logic [5:0] minute,
  output logic [4:0] hour,
  output logic [4:0] day_of_month,
  output logic [3:0] month,
  output logic [7:0] year_since_1900,
  output logic [2:0] weekday,
  output logic [8:0] day_of_year,
  output logic dst_active,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [17:0] cfg_data
);
  import estlc_pkg::*;
  ctl_t ctl;
  sts_t sts;

  estlc_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .ctl);

  estlc_datapath #(.DST_PAIRS(DST_PAIRS)) u_dp (.clk, .rst, .ctl, .sts, .cfg_we,
    .cfg_index, .cfg_data, .command, .table_index, .value, .second, .minute, .hour,
    .day_of_month, .month, .year_since_1900, .weekday, .day_of_year, .dst_active);
endmodule
